FILE: sv/dhlt_pkg.sv
// Shared constants, types and arithmetic helpers for the DH link transform core.
package dhlt_pkg;

   localparam int SINCOS_STAGES_DEF = 16;
   localparam int NSTAGE_MAX        = 24;

   localparam logic signed [33:0] Q30_GAIN  = 34'sd652032874;
   localparam logic [32:0]        RAD_SCALE = 33'd6746518852;
   localparam logic signed [17:0] Q16_ONE   = 18'sd65536;

   localparam logic [31:0] ATAN_Q30 [NSTAGE_MAX] = '{
      32'h3243F6A8, 32'h1DAC6705, 32'h0FADBAFC, 32'h07F56EA6, 32'h03FEAB76, 32'h01FFD55B,
      32'h00FFFAAA, 32'h007FFF55, 32'h003FFFEA, 32'h001FFFFD, 32'h000FFFFF, 32'h0007FFFF,
      32'h0003FFFF, 32'h0001FFFF, 32'h0000FFFF, 32'h00007FFF, 32'h00003FFF, 32'h00001FFF,
      32'h00000FFF, 32'h000007FF, 32'h000003FF, 32'h000001FF, 32'h000000FF, 32'h0000007F};

   // Register indexes of the configuration port.
   localparam logic [2:0] CSR_LINK_R = 3'd0;
   localparam logic [2:0] CSR_LINK_D = 3'd1;
   localparam logic [2:0] CSR_TWIST  = 3'd2;
   localparam logic [2:0] CSR_JOINT  = 3'd3;
   localparam logic [2:0] CSR_CONV   = 3'd4;
   localparam logic [2:0] CSR_FREE   = 3'd5;

   // Free variable selector codes.
   localparam logic [2:0] FREE_R     = 3'd1;
   localparam logic [2:0] FREE_ALPHA = 3'd2;
   localparam logic [2:0] FREE_D     = 3'd3;
   localparam logic [2:0] FREE_THETA = 3'd4;

   localparam logic CONV_CLASSIC  = 1'b0;
   localparam logic CONV_MODIFIED = 1'b1;

   localparam logic [1:0] ROW_LAST = 2'd2;

   typedef struct packed {
      logic signed [33:0] x;
      logic signed [33:0] y;
      logic signed [32:0] z;
   } cordic_type;

   typedef struct packed {
      logic [1:0]         quad_t;
      logic [1:0]         quad_a;
      logic signed [31:0] r;
      logic signed [31:0] d;
      logic               conv;
      logic               status;
      logic [31:0]        readback;
   } side_type;

   typedef struct packed {
      logic signed [17:0] ct;
      logic signed [17:0] st;
      logic signed [17:0] ca;
      logic signed [17:0] sa;
   } trig_type;

   typedef struct packed {
      logic signed [35:0] st_ca;
      logic signed [35:0] st_sa;
      logic signed [35:0] ct_ca;
      logic signed [35:0] ct_sa;
      logic signed [49:0] r_ct;
      logic signed [49:0] r_st;
      logic signed [49:0] d_sa;
      logic signed [49:0] d_ca;
   } prod_type;

   function automatic cordic_type cordic_step(input cordic_type c, input int unsigned sh,
                                              input logic [31:0] at);
      cordic_type         n;
      logic signed [33:0] dx;
      logic signed [33:0] dy;
      logic signed [32:0] za;
      dx = c.y >>> sh;
      dy = c.x >>> sh;
      za = signed'({1'b0, at});
      if (!c.z[32]) begin
         n.x = c.x - dx;
         n.y = c.y + dy;
         n.z = c.z - za;
      end else begin
         n.x = c.x + dx;
         n.y = c.y - dy;
         n.z = c.z + za;
      end
      return n;
   endfunction

   function automatic logic signed [17:0] clamp_q1(input logic signed [39:0] v);
      if (v < 40'sd0 - 40'sd65536) return -Q16_ONE;
      if (v > 40'sd65536) return Q16_ONE;
      return v[17:0];
   endfunction

   function automatic logic signed [31:0] sat32(input logic signed [39:0] v);
      if (v < -40'sd2147483648) return 32'sh80000000;
      if (v > 40'sd2147483647) return 32'sh7FFFFFFF;
      return v[31:0];
   endfunction

   // Q2.30 CORDIC output rounded to Q1.16 and clamped.
   function automatic logic signed [17:0] round_q30(input logic signed [33:0] v);
      logic signed [39:0] w;
      w = {{6{v[33]}}, v} + 40'sd8192;
      w = w >>> 14;
      return clamp_q1(w);
   endfunction

   // Q16 product rounded half up.
   function automatic logic signed [39:0] rnd_q16(input logic signed [49:0] p);
      logic signed [50:0] w;
      w = {p[49], p} + 51'sd32768;
      w = w >>> 16;
      return w[39:0];
   endfunction

endpackage

FILE: sv/dh_link_transform_core.sv
// Denavit-Hartenberg link transform core with pipelined CORDIC sine and cosine.
// Items pass stage 0, the CORDIC, rounding, product and assembly stages, then the row buffer.
// The item rate is set by the three row transfers on the result side and by rsp_stall.
// Items enter back to back; the pipeline halts only while the row buffer is busy and full.
// Reset is synchronous and active high; it clears all valid bits and loads the register
// reset values (modified convention, no free variable, all parameters zero).
module dh_link_transform_core
   import dhlt_pkg::*;
#(
   parameter int SINCOS_STAGES = SINCOS_STAGES_DEF
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_stall,
   input  logic signed [31:0] req_joint_value,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output logic [1:0]         rsp_row_index,
   output logic signed [17:0] rsp_rot_col0,
   output logic signed [17:0] rsp_rot_col1,
   output logic signed [17:0] rsp_rot_col2,
   output logic signed [31:0] rsp_offset,
   output logic               rsp_status,
   output logic signed [31:0] rsp_free_readback,
   output logic               rsp_last_row,
   input  logic               csr_valid,
   output logic               csr_ready,
   input  logic [2:0]         csr_index,
   input  logic [31:0]        csr_data
);

   // Configuration registers. Each item overwrites the free parameter unless a CSR write wins.
   logic signed [31:0] link_r_ff;
   logic signed [31:0] link_d_ff;
   logic [15:0]        twist_ff;
   logic [15:0]        joint_ff;
   logic               conv_ff;
   logic [2:0]         free_sel_ff;

   logic               csr_write;
   logic               req_transfer;
   logic               rsp_transfer;
   logic               out_free;
   logic               adv;

   logic signed [31:0] eff_r_in;
   logic signed [31:0] eff_d_in;
   logic [15:0]        eff_alpha_in;
   logic [15:0]        eff_theta_in;
   logic               eff_status_in;
   logic [31:0]        eff_readback_in;

   // Stage 0: effective link parameters. Only the residue inside the quadrant is kept
   // here; the quadrant itself travels with the side data.
   logic               v0_ff;
   logic [13:0]        theta0_ff;
   logic [13:0]        alpha0_ff;
   side_type           side0_ff;

   // CORDIC stages; index 0 holds the initial vector.
   logic               vc_ff   [SINCOS_STAGES+1];
   cordic_type         cst_ff  [SINCOS_STAGES+1];
   cordic_type         csa_ff  [SINCOS_STAGES+1];
   side_type           sidec_ff[SINCOS_STAGES+1];

   // Rounding and quadrant stage, product stage, final assembly stage.
   logic               vr_ff;
   trig_type           trig_r_ff;
   side_type           side_r_ff;
   logic               vm_ff;
   prod_type           prod_ff;
   trig_type           trig_m_ff;
   side_type           side_m_ff;
   logic               vf_ff;
   logic signed [17:0] rot_f_ff [3][3];
   logic signed [31:0] off_f_ff [3];
   logic               status_f_ff;
   logic [31:0]        readback_f_ff;

   logic signed [17:0] rot_in [3][3];
   logic signed [31:0] off_in [3];
   trig_type           trig_in;

   // Row buffer that serializes one item into three transfers.
   logic               out_valid_ff;
   logic [1:0]         out_row_ff;
   logic signed [17:0] out_rot_ff [3][3];
   logic signed [31:0] out_off_ff [3];
   logic               out_status_ff;
   logic [31:0]        out_readback_ff;

   assign csr_ready    = 1'b1;
   assign csr_write    = csr_valid && csr_ready;
   assign rsp_transfer = rsp_valid && !rsp_stall;

   // The buffer frees up once the final row transfer completes. An empty tail stage
   // lets the pipeline move on even while the buffer is busy.
   assign out_free     = !out_valid_ff || (rsp_transfer && (out_row_ff == ROW_LAST));
   assign adv          = out_free || !vf_ff;
   assign req_stall    = !adv;
   assign req_transfer = req_valid && !req_stall;

   // The joint value replaces the selected parameter; an angle uses its low 16 bits.
   always_comb begin
      eff_r_in        = link_r_ff;
      eff_d_in        = link_d_ff;
      eff_alpha_in    = twist_ff;
      eff_theta_in    = joint_ff;
      eff_status_in   = 1'b0;
      eff_readback_in = 32'd0;
      unique case (free_sel_ff)
         FREE_R: begin
            eff_r_in        = req_joint_value;
            eff_readback_in = req_joint_value;
         end
         FREE_ALPHA: begin
            eff_alpha_in    = req_joint_value[15:0];
            eff_readback_in = {16'd0, req_joint_value[15:0]};
         end
         FREE_D: begin
            eff_d_in        = req_joint_value;
            eff_readback_in = req_joint_value;
         end
         FREE_THETA: begin
            eff_theta_in    = req_joint_value[15:0];
            eff_readback_in = {16'd0, req_joint_value[15:0]};
         end
         default: begin
            eff_status_in   = 1'b1;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         link_r_ff   <= '0;
         link_d_ff   <= '0;
         twist_ff    <= '0;
         joint_ff    <= '0;
         conv_ff     <= CONV_MODIFIED;
         free_sel_ff <= '0;
      end else if (csr_write) begin
         unique case (csr_index)
            CSR_LINK_R: link_r_ff   <= csr_data;
            CSR_LINK_D: link_d_ff   <= csr_data;
            CSR_TWIST:  twist_ff    <= csr_data[15:0];
            CSR_JOINT:  joint_ff    <= csr_data[15:0];
            CSR_CONV:   conv_ff     <= csr_data[0];
            CSR_FREE:   free_sel_ff <= csr_data[2:0];
            default:    ;
         endcase
      end else if (req_transfer) begin
         link_r_ff <= eff_r_in;
         link_d_ff <= eff_d_in;
         twist_ff  <= eff_alpha_in;
         joint_ff  <= eff_theta_in;
      end
   end

   // Stage 0.
   always_ff @(posedge clock) begin
      if (reset) begin
         v0_ff <= 1'b0;
      end else if (adv) begin
         v0_ff <= req_transfer;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         theta0_ff         <= eff_theta_in[13:0];
         alpha0_ff         <= eff_alpha_in[13:0];
         side0_ff.quad_t   <= eff_theta_in[15:14];
         side0_ff.quad_a   <= eff_alpha_in[15:14];
         side0_ff.r        <= eff_r_in;
         side0_ff.d        <= eff_d_in;
         side0_ff.conv     <= conv_ff;
         side0_ff.status   <= eff_status_in;
         side0_ff.readback <= eff_readback_in;
      end
   end

   // Stage 1: the residue inside the quadrant becomes a Q30 radian angle.
   logic [46:0] zt_prod;
   logic [46:0] za_prod;

   assign zt_prod = {33'd0, theta0_ff} * {14'd0, RAD_SCALE} + 47'd32768;
   assign za_prod = {33'd0, alpha0_ff} * {14'd0, RAD_SCALE} + 47'd32768;

   always_ff @(posedge clock) begin
      if (reset) begin
         vc_ff[0] <= 1'b0;
      end else if (adv) begin
         vc_ff[0] <= v0_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         cst_ff[0].x  <= Q30_GAIN;
         cst_ff[0].y  <= '0;
         cst_ff[0].z  <= signed'({2'b00, zt_prod[46:16]});
         csa_ff[0].x  <= Q30_GAIN;
         csa_ff[0].y  <= '0;
         csa_ff[0].z  <= signed'({2'b00, za_prod[46:16]});
         sidec_ff[0]  <= side0_ff;
      end
   end

   // One micro-rotation per stage for both angles.
   for (genvar i = 0; i < SINCOS_STAGES; i++) begin : g_cordic
      always_ff @(posedge clock) begin
         if (reset) begin
            vc_ff[i+1] <= 1'b0;
         end else if (adv) begin
            vc_ff[i+1] <= vc_ff[i];
         end
      end

      always_ff @(posedge clock) begin
         if (adv) begin
            cst_ff[i+1]   <= cordic_step(cst_ff[i], i, ATAN_Q30[i]);
            csa_ff[i+1]   <= cordic_step(csa_ff[i], i, ATAN_Q30[i]);
            sidec_ff[i+1] <= sidec_ff[i];
         end
      end
   end

   // Rounding and quadrant rotation.
   logic signed [17:0] cr_t;
   logic signed [17:0] sr_t;
   logic signed [17:0] cr_a;
   logic signed [17:0] sr_a;

   assign cr_t = round_q30(cst_ff[SINCOS_STAGES].x);
   assign sr_t = round_q30(cst_ff[SINCOS_STAGES].y);
   assign cr_a = round_q30(csa_ff[SINCOS_STAGES].x);
   assign sr_a = round_q30(csa_ff[SINCOS_STAGES].y);

   always_comb begin
      unique case (sidec_ff[SINCOS_STAGES].quad_t)
         2'd0:    begin trig_in.ct = cr_t;  trig_in.st = sr_t;  end
         2'd1:    begin trig_in.ct = -sr_t; trig_in.st = cr_t;  end
         2'd2:    begin trig_in.ct = -cr_t; trig_in.st = -sr_t; end
         default: begin trig_in.ct = sr_t;  trig_in.st = -cr_t; end
      endcase
      unique case (sidec_ff[SINCOS_STAGES].quad_a)
         2'd0:    begin trig_in.ca = cr_a;  trig_in.sa = sr_a;  end
         2'd1:    begin trig_in.ca = -sr_a; trig_in.sa = cr_a;  end
         2'd2:    begin trig_in.ca = -cr_a; trig_in.sa = -sr_a; end
         default: begin trig_in.ca = sr_a;  trig_in.sa = -cr_a; end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vr_ff <= 1'b0;
         vm_ff <= 1'b0;
         vf_ff <= 1'b0;
      end else if (adv) begin
         vr_ff <= vc_ff[SINCOS_STAGES];
         vm_ff <= vr_ff;
         vf_ff <= vm_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         trig_r_ff <= trig_in;
         side_r_ff <= sidec_ff[SINCOS_STAGES];
      end
   end

   // Product stage: every multiplier is independent and registered.
   always_ff @(posedge clock) begin
      if (adv) begin
         prod_ff.st_ca <= trig_r_ff.st * trig_r_ff.ca;
         prod_ff.st_sa <= trig_r_ff.st * trig_r_ff.sa;
         prod_ff.ct_ca <= trig_r_ff.ct * trig_r_ff.ca;
         prod_ff.ct_sa <= trig_r_ff.ct * trig_r_ff.sa;
         prod_ff.r_ct  <= side_r_ff.r * trig_r_ff.ct;
         prod_ff.r_st  <= side_r_ff.r * trig_r_ff.st;
         prod_ff.d_sa  <= side_r_ff.d * trig_r_ff.sa;
         prod_ff.d_ca  <= side_r_ff.d * trig_r_ff.ca;
         trig_m_ff     <= trig_r_ff;
         side_m_ff     <= side_r_ff;
      end
   end

   // Final assembly: round the products and pick the convention's layout.
   logic signed [39:0] q_st_ca;
   logic signed [39:0] q_st_sa;
   logic signed [39:0] q_ct_ca;
   logic signed [39:0] q_ct_sa;
   logic signed [39:0] q_r_ct;
   logic signed [39:0] q_r_st;
   logic signed [39:0] q_d_sa;
   logic signed [39:0] q_d_ca;

   assign q_st_ca = rnd_q16({{14{prod_ff.st_ca[35]}}, prod_ff.st_ca});
   assign q_st_sa = rnd_q16({{14{prod_ff.st_sa[35]}}, prod_ff.st_sa});
   assign q_ct_ca = rnd_q16({{14{prod_ff.ct_ca[35]}}, prod_ff.ct_ca});
   assign q_ct_sa = rnd_q16({{14{prod_ff.ct_sa[35]}}, prod_ff.ct_sa});
   assign q_r_ct  = rnd_q16(prod_ff.r_ct);
   assign q_r_st  = rnd_q16(prod_ff.r_st);
   assign q_d_sa  = rnd_q16(prod_ff.d_sa);
   assign q_d_ca  = rnd_q16(prod_ff.d_ca);

   always_comb begin
      if (side_m_ff.conv == CONV_CLASSIC) begin
         rot_in[0][0] = trig_m_ff.ct;
         rot_in[0][1] = clamp_q1(-q_st_ca);
         rot_in[0][2] = clamp_q1(q_st_sa);
         rot_in[1][0] = trig_m_ff.st;
         rot_in[1][1] = clamp_q1(q_ct_ca);
         rot_in[1][2] = clamp_q1(-q_ct_sa);
         rot_in[2][0] = '0;
         rot_in[2][1] = trig_m_ff.sa;
         rot_in[2][2] = trig_m_ff.ca;
         off_in[0]    = sat32(q_r_ct);
         off_in[1]    = sat32(q_r_st);
         off_in[2]    = side_m_ff.d;
      end else begin
         rot_in[0][0] = trig_m_ff.ct;
         rot_in[0][1] = -trig_m_ff.st;
         rot_in[0][2] = '0;
         rot_in[1][0] = clamp_q1(q_st_ca);
         rot_in[1][1] = clamp_q1(q_ct_ca);
         rot_in[1][2] = -trig_m_ff.sa;
         rot_in[2][0] = clamp_q1(q_st_sa);
         rot_in[2][1] = clamp_q1(q_ct_sa);
         rot_in[2][2] = trig_m_ff.ca;
         off_in[0]    = side_m_ff.r;
         off_in[1]    = sat32(-q_d_sa);
         off_in[2]    = sat32(q_d_ca);
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         rot_f_ff      <= rot_in;
         off_f_ff      <= off_in;
         status_f_ff   <= side_m_ff.status;
         readback_f_ff <= side_m_ff.readback;
      end
   end

   // Row buffer: loads a finished item when free, then steps through its rows.
   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
         out_row_ff   <= '0;
      end else begin
         if (rsp_transfer) begin
            if (out_row_ff == ROW_LAST) begin
               out_valid_ff <= 1'b0;
            end
            out_row_ff <= out_row_ff + 2'd1;
         end
         if (vf_ff && out_free) begin
            out_valid_ff <= 1'b1;
            out_row_ff   <= '0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (vf_ff && out_free) begin
         out_rot_ff      <= rot_f_ff;
         out_off_ff      <= off_f_ff;
         out_status_ff   <= status_f_ff;
         out_readback_ff <= readback_f_ff;
      end
   end

   assign rsp_valid         = out_valid_ff;
   assign rsp_row_index     = out_row_ff;
   assign rsp_rot_col0      = out_rot_ff[out_row_ff][0];
   assign rsp_rot_col1      = out_rot_ff[out_row_ff][1];
   assign rsp_rot_col2      = out_rot_ff[out_row_ff][2];
   assign rsp_offset        = out_off_ff[out_row_ff];
   assign rsp_status        = out_status_ff;
   assign rsp_free_readback = out_readback_ff;
   assign rsp_last_row      = (out_row_ff == ROW_LAST);

endmodule
